// ===== hw/rtl/bpa_pkg.sv =====
// Shared types, codes and helpers for the bitmap page allocator.
`timescale 1ns / 1ps
package bpa_pkg;

  localparam int unsigned ADDR_W = 48;
  localparam int unsigned RUN_W  = 17;
  localparam int unsigned WORD_W = 64;
  localparam int unsigned BIT_W  = 6;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FAIL    = 2'd1,
    ST_IGNORED = 2'd2
  } status_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic {
    CFG_REGION_BASE = 1'b0,
    CFG_PAGE_COUNT  = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic             op;
    logic [RUN_W-1:0] page_run;
    logic [ADDR_W-1:0] free_address;
  } request_t;

  typedef struct packed {
    logic [ADDR_W-1:0] alloc_address;
    logic [1:0]        status;
  } response_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_CHECK,
    S_FREE_DIV,
    S_FREE_CHK,
    S_RD,
    S_SCAN,
    S_MARK_RD,
    S_MARK_WR,
    S_ADDR,
    S_RESP
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic clear_step;
    logic check;
    logic div_step;
    logic free_chk;
    logic rd_issue;
    logic scan_bit;
    logic mark_rd;
    logic mark_wr;
    logic addr_calc;
    logic respond;
  } bpa_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic clear_last;
    logic is_free;
    logic bad_req;
    logic div_done;
    logic free_bad;
    logic scan_end;
    logic scan_found;
    logic word_end;
    logic mark_last;
  } bpa_stat_t;

endpackage

// ===== hw/rtl/bpa_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bpa_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/bpa_datapath.sv =====
// Datapath: map memory, scan counters, page division and address arithmetic.
`timescale 1ns / 1ps
module bpa_datapath #(
  parameter int unsigned MAP_PAGES  = 65536,
  parameter int unsigned PAGE_BYTES = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  bpa_pkg::bpa_cmd_t               cmd,
  output bpa_pkg::bpa_stat_t              stat,
  input  bpa_pkg::request_t               req,
  input  logic [bpa_pkg::ADDR_W-1:0]      region_base,
  input  logic [bpa_pkg::RUN_W-1:0]       page_count,
  output bpa_pkg::response_t              resp
);

  localparam int unsigned WORDS  = MAP_PAGES / bpa_pkg::WORD_W;
  localparam int unsigned WA_W   = $clog2(WORDS);
  localparam int unsigned PG_W   = $clog2(MAP_PAGES) + 1;
  localparam int unsigned SH_W   = $clog2(PAGE_BYTES);
  localparam int unsigned FE_W   = ((PG_W > bpa_pkg::RUN_W) ? PG_W : bpa_pkg::RUN_W) + 1;

  // Map memory ports.
  logic                       we;
  logic [WA_W-1:0]            waddr;
  logic [bpa_pkg::WORD_W-1:0] wdata;
  logic [WA_W-1:0]            raddr;
  logic [bpa_pkg::WORD_W-1:0] rdata;

  bpa_ram #(.WIDTH(bpa_pkg::WORD_W), .DEPTH(WORDS)) u_map (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Working registers.
  bpa_pkg::request_t           rq;
  logic [PG_W-1:0]             total;
  logic [PG_W-1:0]             pg;
  logic [PG_W-1:0]             run;
  logic [PG_W-1:0]             start;
  logic [PG_W-1:0]             mark_pg;
  logic [PG_W-1:0]             mark_end;
  logic [WA_W-1:0]             clr_idx;
  logic [bpa_pkg::WORD_W-1:0]  word;
  logic [bpa_pkg::ADDR_W-1:0]  offset;
  logic [bpa_pkg::ADDR_W-1:0]  quot;
  logic [bpa_pkg::ADDR_W-1:0]  result_addr;
  logic [1:0]                  result_st;
  logic                        free_mode;

  logic [PG_W-1:0] n_ext;
  logic            bit_used;
  logic [PG_W-1:0] run_inc;
  logic [FE_W-1:0] free_end;
  logic [bpa_pkg::WORD_W-1:0] mask_bit;

  assign n_ext    = PG_W'(rq.page_run);
  assign bit_used = word[pg[bpa_pkg::BIT_W-1:0]];
  assign run_inc  = run + PG_W'(1);
  assign free_end = FE_W'(quot[PG_W-1:0]) + FE_W'(rq.page_run);
  assign mask_bit = bpa_pkg::WORD_W'(1) << mark_pg[bpa_pkg::BIT_W-1:0];

  // Status back to the controller.
  always_comb begin
    stat.clear_last = (clr_idx == WA_W'(WORDS - 1));
    stat.is_free    = (rq.op == bpa_pkg::OP_FREE);
    stat.bad_req    = (rq.op == bpa_pkg::OP_FREE)
                      ? (rq.free_address == '0 || rq.page_run == '0 ||
                         rq.free_address < region_base)
                      : (rq.page_run == '0 || n_ext > total ||
                         32'(rq.page_run) > MAP_PAGES);
    stat.div_done   = 1'b1;
    stat.free_bad   = (quot >= bpa_pkg::ADDR_W'(total));
    stat.scan_end   = (pg >= total);
    stat.scan_found = !bit_used && (run_inc == n_ext);
    stat.word_end   = (pg[bpa_pkg::BIT_W-1:0] == '1);
    stat.mark_last  = (mark_pg + PG_W'(1) >= mark_end);
  end

  // Memory port steering.
  always_comb begin
    we    = 1'b0;
    waddr = mark_pg[bpa_pkg::BIT_W +: WA_W];
    wdata = free_mode ? (word & ~mask_bit) : (word | mask_bit);
    raddr = pg[bpa_pkg::BIT_W +: WA_W];
    if (cmd.clear_step) begin
      we    = 1'b1;
      waddr = clr_idx;
      wdata = '0;
    end else if (cmd.mark_wr) begin
      we = 1'b1;
    end
    if (cmd.mark_rd || cmd.mark_wr) begin
      raddr = mark_pg[bpa_pkg::BIT_W +: WA_W];
    end
  end

  // Clearing pass index.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clear_step) begin
      clr_idx <= clr_idx + WA_W'(1);
    end
  end

  // Request registers and sequencing arithmetic.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rq    <= req;
      total <= (32'(page_count) > MAP_PAGES) ? PG_W'(MAP_PAGES) : PG_W'(page_count);
      pg    <= '0;
      run   <= '0;
      offset <= req.free_address - region_base;
      result_addr <= '0;
      result_st   <= bpa_pkg::ST_DONE;
    end
    if (cmd.check) begin
      result_st <= (rq.op == bpa_pkg::OP_FREE) ? bpa_pkg::ST_IGNORED
                                               : bpa_pkg::ST_FAIL;
    end
    if (cmd.div_step) begin
      quot <= offset >> SH_W;
    end
    if (cmd.free_chk) begin
      free_mode <= 1'b1;
      mark_pg   <= quot[PG_W-1:0];
      mark_end  <= (free_end > FE_W'(total)) ? total : free_end[PG_W-1:0];
      result_st <= stat.free_bad ? bpa_pkg::ST_IGNORED : bpa_pkg::ST_DONE;
    end
    if (cmd.scan_bit) begin
      if (bit_used) begin
        run <= '0;
      end else begin
        run <= run_inc;
      end
      if (stat.scan_found) begin
        free_mode <= 1'b0;
        start     <= pg + PG_W'(1) - n_ext;
        mark_pg   <= pg + PG_W'(1) - n_ext;
        mark_end  <= pg + PG_W'(1);
      end
      pg <= pg + PG_W'(1);
    end
    if (cmd.rd_issue || cmd.mark_rd) begin
      word <= rdata;
    end
    if (cmd.mark_wr) begin
      word    <= wdata;
      mark_pg <= mark_pg + PG_W'(1);
    end
    if (cmd.addr_calc) begin
      result_addr <= region_base + (bpa_pkg::ADDR_W'(start) << SH_W);
      result_st   <= bpa_pkg::ST_DONE;
    end
  end

  assign resp.alloc_address = result_addr;
  assign resp.status        = result_st;

endmodule

// ===== hw/rtl/bpa_ctrl.sv =====
// Controller state machine for the bitmap page allocator.
`timescale 1ns / 1ps
module bpa_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  output bpa_pkg::bpa_cmd_t  cmd,
  input  bpa_pkg::bpa_stat_t stat
);

  bpa_pkg::state_t state, state_next;
  logic            rd_wait, rd_wait_next;
  logic            same_word;

  // The read data is registered; a wait flag covers that.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= bpa_pkg::S_CLEAR;
      rd_wait <= 1'b0;
    end else begin
      state   <= state_next;
      rd_wait <= rd_wait_next;
    end
  end

  assign same_word = 1'b0;

  // Next state.
  always_comb begin
    state_next   = state;
    rd_wait_next = 1'b0;
    unique case (state)
      bpa_pkg::S_IDLE:     if (start) state_next = bpa_pkg::S_CHECK;
      bpa_pkg::S_CLEAR:    if (stat.clear_last) state_next = bpa_pkg::S_IDLE;
      bpa_pkg::S_CHECK: begin
        priority if (stat.bad_req) state_next = bpa_pkg::S_RESP;
        else if (stat.is_free) state_next = bpa_pkg::S_FREE_DIV;
        else state_next = bpa_pkg::S_RD;
      end
      bpa_pkg::S_FREE_DIV: state_next = bpa_pkg::S_FREE_CHK;
      bpa_pkg::S_FREE_CHK: begin
        if (stat.free_bad) state_next = bpa_pkg::S_RESP;
        else state_next = bpa_pkg::S_MARK_RD;
      end
      bpa_pkg::S_RD: begin
        if (stat.scan_end) state_next = bpa_pkg::S_RESP;
        else if (!rd_wait) rd_wait_next = 1'b1;
        else state_next = bpa_pkg::S_SCAN;
      end
      bpa_pkg::S_SCAN: begin
        priority if (stat.scan_end) state_next = bpa_pkg::S_RESP;
        else if (stat.scan_found) state_next = bpa_pkg::S_MARK_RD;
        else if (stat.word_end) state_next = bpa_pkg::S_RD;
      end
      bpa_pkg::S_MARK_RD: begin
        if (!rd_wait) rd_wait_next = 1'b1;
        else state_next = bpa_pkg::S_MARK_WR;
      end
      bpa_pkg::S_MARK_WR: begin
        priority if (stat.mark_last && !stat.is_free) state_next = bpa_pkg::S_ADDR;
        else if (stat.mark_last) state_next = bpa_pkg::S_RESP;
        else state_next = bpa_pkg::S_MARK_RD;
      end
      bpa_pkg::S_ADDR:     state_next = bpa_pkg::S_RESP;
      bpa_pkg::S_RESP:     state_next = bpa_pkg::S_IDLE;
      default:             state_next = bpa_pkg::S_IDLE;
    endcase
  end

  // Outputs and datapath commands.
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    done = 1'b0;
    unique case (state)
      bpa_pkg::S_IDLE: begin
        busy     = same_word;
        cmd.load = start;
      end
      bpa_pkg::S_CLEAR:    cmd.clear_step = 1'b1;
      bpa_pkg::S_CHECK:    cmd.check = stat.bad_req;
      bpa_pkg::S_FREE_DIV: cmd.div_step = 1'b1;
      bpa_pkg::S_FREE_CHK: cmd.free_chk = 1'b1;
      bpa_pkg::S_RD:       cmd.rd_issue = rd_wait;
      bpa_pkg::S_SCAN: begin
        if (stat.scan_end) cmd.check = 1'b1;
        else cmd.scan_bit = 1'b1;
      end
      // Each read pass steers the read to the marked word; the second keeps the data.
      bpa_pkg::S_MARK_RD:  cmd.mark_rd = 1'b1;
      bpa_pkg::S_MARK_WR:  cmd.mark_wr = 1'b1;
      bpa_pkg::S_ADDR:     cmd.addr_calc = 1'b1;
      bpa_pkg::S_RESP:     done = 1'b1;
      default:             busy = 1'b1;
    endcase
    if (state == bpa_pkg::S_RD && stat.scan_end) cmd.check = 1'b1;
  end

endmodule

// ===== hw/rtl/bitmap_page_allocator.sv =====
// Top level of the bitmap first-fit page allocator.
// An allocate reads the map word by word and scans it page by page, then marks the run
// found and forms its address; a free divides its offset into a page index, checks it
// and clears the pages. A request rejected on its fields, or a free rejected on its page
// index, goes straight to its result. One transaction at a time; the next is taken in
// the cycle after the result. After reset a clearing pass zeroes the map (busy high).
`timescale 1ns / 1ps
module bitmap_page_allocator #(
  parameter int unsigned MAP_PAGES  = 65536,
  parameter int unsigned PAGE_BYTES = 4096
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  bpa_pkg::request_t            request,
  output logic                         done,
  output bpa_pkg::response_t           response,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_index,
  input  logic [bpa_pkg::ADDR_W-1:0]   cfg_data
);

  bpa_pkg::bpa_cmd_t  cmd;
  bpa_pkg::bpa_stat_t stat;
  logic [bpa_pkg::ADDR_W-1:0] region_base;
  logic [bpa_pkg::RUN_W-1:0]  page_count;

  // Configuration registers.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      region_base <= '0;
      page_count  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bpa_pkg::CFG_REGION_BASE: region_base <= cfg_data;
        bpa_pkg::CFG_PAGE_COUNT:  page_count  <= cfg_data[bpa_pkg::RUN_W-1:0];
        default: ;
      endcase
    end
  end

  bpa_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .done (done),
    .cmd  (cmd),
    .stat (stat)
  );

  bpa_datapath #(.MAP_PAGES(MAP_PAGES), .PAGE_BYTES(PAGE_BYTES)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .req        (request),
    .region_base(region_base),
    .page_count (page_count),
    .resp       (response)
  );

endmodule

// ===== hw/rtl/bpa_checker.sv =====
// Port-level checker for the bitmap page allocator, bound to the top level.
`timescale 1ns / 1ps
module bpa_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input bpa_pkg::response_t response
);

  // An accepted transaction makes the block busy next cycle.
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("busy not raised after start");

  // A result strobe lasts one cycle.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held longer than one cycle");

  // The block is idle right after a result.
  a_idle_after_done: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy) else $error("busy after done");

  // Failure and ignored results carry a zero address.
  a_zero_addr: assert property (@(posedge clk) disable iff (rst)
    done && response.status != bpa_pkg::ST_DONE |-> response.alloc_address == '0)
    else $error("nonzero address on failed transaction");

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .done    (done),
  .response(response)
);

// ===== dv/tb.sv =====
// Self-checking testbench for the bitmap first-fit page allocator.
`timescale 1ns / 1ps
module tb;

  localparam int unsigned MAP_PAGES  = 65536;
  localparam int unsigned PAGE_BYTES = 4096;
  localparam longint unsigned CYCLE_LIMIT = 20_000_000;
  localparam int unsigned RANDOM_PHASES = 12;
  localparam int unsigned PHASE_ITEMS   = 155;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        start = 1'b0;
  logic                        busy;
  bpa_pkg::request_t           request = '0;
  logic                        done;
  bpa_pkg::response_t          response;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic                        cfg_index = 1'b0;
  logic [bpa_pkg::ADDR_W-1:0]  cfg_data = '0;

  bitmap_page_allocator #(
    .MAP_PAGES (MAP_PAGES),
    .PAGE_BYTES(PAGE_BYTES)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .request  (request),
    .done     (done),
    .response (response),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #10 clk = ~clk;

  // Shadow copy of the page map and the two registers.
  bit                          page_used [MAP_PAGES];
  logic [bpa_pkg::ADDR_W-1:0]  shadow_base = '0;
  logic [bpa_pkg::RUN_W-1:0]   shadow_count = '0;

  bpa_pkg::request_t           request_q[$];
  bpa_pkg::response_t          response_q[$];
  int unsigned                 mismatches = 0;
  longint unsigned             cycle_count = 0;

  // Applies one request to the shadow map and returns the answer it should get.
  function automatic bpa_pkg::response_t apply_request(bpa_pkg::request_t r);
    bpa_pkg::response_t          res;
    longint unsigned             live, run, first, p, i;
    logic [bpa_pkg::ADDR_W-1:0]  offset;
    live = (shadow_count > MAP_PAGES) ? MAP_PAGES : shadow_count;
    res.alloc_address = '0;
    res.status = bpa_pkg::ST_DONE;
    if (r.op == bpa_pkg::OP_ALLOC) begin
      res.status = bpa_pkg::ST_FAIL;
      if (r.page_run != 0 && r.page_run <= live) begin
        run = 0;
        for (p = 0; p < live; p++) begin
          if (page_used[p]) begin
            run = 0;
          end else begin
            run++;
            if (run == r.page_run) begin
              first = p + 1 - run;
              for (i = first; i <= p; i++) page_used[i] = 1'b1;
              res.alloc_address = shadow_base + bpa_pkg::ADDR_W'(first * PAGE_BYTES);
              res.status = bpa_pkg::ST_DONE;
              break;
            end
          end
        end
      end
    end else if (r.free_address == 0 || r.page_run == 0 ||
                 r.free_address < shadow_base) begin
      res.status = bpa_pkg::ST_IGNORED;
    end else begin
      offset = r.free_address - shadow_base;
      p = longint'(offset) / PAGE_BYTES;
      if (p >= live) begin
        res.status = bpa_pkg::ST_IGNORED;
      end else begin
        for (i = 0; i < r.page_run && p + i < live; i++) page_used[p + i] = 1'b0;
      end
    end
    return res;
  endfunction

  function automatic logic [bpa_pkg::ADDR_W-1:0] rand_address();
    return bpa_pkg::ADDR_W'({$urandom, $urandom});
  endfunction

  // Request driver: random gaps between transactions, with bursts of none.
  always @(posedge clk) begin : drive_requests
    int unsigned gap;
    int unsigned wait_cycles;
    bit          burst;
    if (rst) begin
      start <= 1'b0;
      gap = 0;
    end else if (start) begin
      if (!busy) begin
        response_q.push_back(apply_request(request));
        if ($urandom_range(0, 99) < 4) burst = !burst;
        wait_cycles = burst ? 0 : $urandom_range(0, 11);
        if (wait_cycles == 0 && request_q.size() > 0) begin
          request <= request_q.pop_front();
        end else begin
          start <= 1'b0;
          gap = wait_cycles;
        end
      end
    end else if (gap > 0) begin
      gap--;
    end else if (request_q.size() > 0) begin
      request <= request_q.pop_front();
      start <= 1'b1;
    end
  end

  // Response monitor: each strobed result is compared with the oldest prediction.
  always @(posedge clk) begin : check_responses
    bpa_pkg::response_t want;
    if (!rst && done) begin
      if (response_q.size() == 0) begin
        $display("%0t: unexpected response, expected none, actual addr=%h status=%0d",
                 $time, response.alloc_address, response.status);
        mismatches++;
      end else begin
        want = response_q.pop_front();
        if (response.alloc_address !== want.alloc_address) begin
          $display("%0t: alloc_address mismatch, expected %h, actual %h",
                   $time, want.alloc_address, response.alloc_address);
          mismatches++;
        end
        if (response.status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, want.status, response.status);
          mismatches++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic push_request(bpa_pkg::op_t op, longint unsigned run,
                              logic [bpa_pkg::ADDR_W-1:0] addr);
    bpa_pkg::request_t r;
    r.op = op;
    r.page_run = bpa_pkg::RUN_W'(run);
    r.free_address = addr;
    request_q.push_back(r);
  endtask

  // Waits until every queued transaction has been answered and the block is idle.
  task automatic wait_idle();
    do @(posedge clk);
    while (request_q.size() != 0 || start || response_q.size() != 0 || busy);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(bpa_pkg::cfg_index_t idx, logic [bpa_pkg::ADDR_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk);
    while (!cfg_ready);
    if (idx == bpa_pkg::CFG_REGION_BASE) shadow_base = value;
    else shadow_count = value[bpa_pkg::RUN_W-1:0];
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(logic [bpa_pkg::ADDR_W-1:0] base,
                           logic [bpa_pkg::RUN_W-1:0] count);
    wait_idle();
    write_reg(bpa_pkg::CFG_REGION_BASE, base);
    write_reg(bpa_pkg::CFG_PAGE_COUNT, bpa_pkg::ADDR_W'(count));
    @(negedge clk);
  endtask

  initial begin : stimulus
    logic [bpa_pkg::ADDR_W-1:0] base;
    int unsigned                count, pick, k, ph;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: rejects, exact fit, full map, ignored frees, free past the end.
    base = 48'h0000_0001_0000;
    configure(base, 17'd40);
    push_request(bpa_pkg::OP_ALLOC, 0, '0);
    push_request(bpa_pkg::OP_ALLOC, 41, '0);
    push_request(bpa_pkg::OP_ALLOC, 1, '0);
    push_request(bpa_pkg::OP_ALLOC, 40, '0);
    push_request(bpa_pkg::OP_ALLOC, 39, '0);
    push_request(bpa_pkg::OP_ALLOC, 1, '0);
    push_request(bpa_pkg::OP_FREE, 1, '0);
    push_request(bpa_pkg::OP_FREE, 0, base);
    push_request(bpa_pkg::OP_FREE, 1, base - 1);
    push_request(bpa_pkg::OP_FREE, 1, base + 40 * PAGE_BYTES);
    push_request(bpa_pkg::OP_FREE, 100, base + PAGE_BYTES + 123);
    push_request(bpa_pkg::OP_FREE, 3, base + 2 * PAGE_BYTES);
    push_request(bpa_pkg::OP_ALLOC, 39, '0);
    push_request(bpa_pkg::OP_FREE, 40, base);

    // Region at the top of the address space: addresses wrap through zero.
    configure(48'hFFFF_FFFF_D000, 17'd8);
    push_request(bpa_pkg::OP_ALLOC, 3, '0);
    push_request(bpa_pkg::OP_ALLOC, 1, '0);
    push_request(bpa_pkg::OP_ALLOC, 4, '0);
    push_request(bpa_pkg::OP_FREE, 8, 48'hFFFF_FFFF_D000);

    // No managed pages at all.
    configure('0, '0);
    push_request(bpa_pkg::OP_ALLOC, 1, '0);
    push_request(bpa_pkg::OP_FREE, 1, 48'h1000);

    // Page count above the map size, whole-map runs.
    base = 48'h0000_0001_2345;
    configure(base, 17'h1FFFF);
    push_request(bpa_pkg::OP_FREE, 17'h1FFFF, base);
    push_request(bpa_pkg::OP_ALLOC, 65536, '0);
    push_request(bpa_pkg::OP_FREE, 5, base + 100 * PAGE_BYTES);
    push_request(bpa_pkg::OP_ALLOC, 5, '0);
    configure(base, 17'h10000);
    push_request(bpa_pkg::OP_FREE, 3, base);
    push_request(bpa_pkg::OP_ALLOC, 2, '0);

    // Random phases with small maps; most requests are well-formed.
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      base = rand_address();
      if (ph % 3 == 0) base[11:0] = '0;
      count = (ph == RANDOM_PHASES - 1) ? $urandom_range(200, 500) : $urandom_range(1, 300);
      configure(base, bpa_pkg::RUN_W'(count));
      push_request(bpa_pkg::OP_FREE, 17'h1FFFF, base);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          push_request(bpa_pkg::OP_ALLOC, $urandom_range(1, count / 6 + 1), rand_address());
        end else if (pick < 85) begin
          push_request(bpa_pkg::OP_FREE, $urandom_range(1, count / 4 + 1),
                       base + bpa_pkg::ADDR_W'($urandom_range(0, count - 1)) * PAGE_BYTES
                       + $urandom_range(0, PAGE_BYTES - 1));
        end else begin
          case ($urandom_range(0, 5))
            0: push_request(bpa_pkg::OP_ALLOC, 0, rand_address());
            1: push_request(bpa_pkg::OP_FREE, 0, base + PAGE_BYTES);
            2: push_request(bpa_pkg::OP_FREE, $urandom_range(1, 20), '0);
            3: push_request(bpa_pkg::OP_FREE, $urandom_range(0, 17'h1FFFF), rand_address());
            4: push_request(bpa_pkg::OP_ALLOC, $urandom_range(0, 17'h1FFFF), rand_address());
            default: push_request(bpa_pkg::OP_FREE, 1, base - $urandom_range(1, 5000));
          endcase
        end
      end
    end

    wait_idle();
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
